/* design/fbc_pkg.sv */
// shared types and constants for the frustum box cull block
package fbc_pkg;

	// plane register layout: a, b, c in Q1.14 and d in scene units, 16 bits each
	localparam int PLANE_BITS     = 64;
	localparam int COEF_BITS      = 16;
	localparam int A_LSB          = 48;
	localparam int B_LSB          = 32;
	localparam int C_LSB          = 16;
	localparam int D_LSB          = 0;
	localparam int FRAC_BITS      = 14;

	// register index port covers up to eight planes
	localparam int CFG_INDEX_BITS = 3;

	// control that travels with a request down the chain
	typedef struct packed {
		logic valid;
		logic culled;
	} chain_ctl_t;

endpackage

/* design/fbc_cell.sv */
// one plane test cell: holds a plane and folds its verdict into the passing request
module fbc_cell #(
	parameter int COORD_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             adv,
	input  logic                             plane_we,
	input  logic [fbc_pkg::PLANE_BITS-1:0]   plane_data,
	input  fbc_pkg::chain_ctl_t              ctl_in,
	input  logic [6*COORD_BITS-1:0]          box_in,
	output fbc_pkg::chain_ctl_t              ctl_out,
	output logic [6*COORD_BITS-1:0]          box_out
);

	localparam int PROD_W = COORD_BITS + fbc_pkg::COEF_BITS;
	localparam int DSC_W  = fbc_pkg::COEF_BITS + fbc_pkg::FRAC_BITS;
	localparam int SUM_W  = ((PROD_W > DSC_W) ? PROD_W : DSC_W) + 2;

	logic [fbc_pkg::PLANE_BITS-1:0] plane_q;

	logic signed [fbc_pkg::COEF_BITS-1:0] a_c, b_c, c_c, d_c;
	logic signed [COORD_BITS-1:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
	logic signed [COORD_BITS-1:0] sel_x, sel_y, sel_z;
	logic signed [PROD_W-1:0] prod_x, prod_y, prod_z;
	logic signed [PROD_W-1:0] prod_x_s1, prod_y_s1, prod_z_s1;
	logic signed [SUM_W-1:0] sum;
	logic outside;

	fbc_pkg::chain_ctl_t ctl_s1, ctl_s2;
	logic [6*COORD_BITS-1:0] box_s1, box_s2;

	// plane register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= '0;
		end else if (plane_we) begin
			plane_q <= plane_data;
		end
	end

	assign a_c = plane_q[fbc_pkg::A_LSB +: fbc_pkg::COEF_BITS];
	assign b_c = plane_q[fbc_pkg::B_LSB +: fbc_pkg::COEF_BITS];
	assign c_c = plane_q[fbc_pkg::C_LSB +: fbc_pkg::COEF_BITS];
	assign d_c = plane_q[fbc_pkg::D_LSB +: fbc_pkg::COEF_BITS];

	assign lo_x = box_in[0*COORD_BITS +: COORD_BITS];
	assign lo_y = box_in[1*COORD_BITS +: COORD_BITS];
	assign lo_z = box_in[2*COORD_BITS +: COORD_BITS];
	assign hi_x = box_in[3*COORD_BITS +: COORD_BITS];
	assign hi_y = box_in[4*COORD_BITS +: COORD_BITS];
	assign hi_z = box_in[5*COORD_BITS +: COORD_BITS];

	// nearest corner per axis: smaller coordinate for a non-negative coefficient,
	// larger one otherwise; the minimum over all eight corners is separable
	always_comb begin
		if (a_c[fbc_pkg::COEF_BITS-1]) begin
			sel_x = (lo_x <= hi_x) ? hi_x : lo_x;
		end else begin
			sel_x = (lo_x <= hi_x) ? lo_x : hi_x;
		end
		if (b_c[fbc_pkg::COEF_BITS-1]) begin
			sel_y = (lo_y <= hi_y) ? hi_y : lo_y;
		end else begin
			sel_y = (lo_y <= hi_y) ? lo_y : hi_y;
		end
		if (c_c[fbc_pkg::COEF_BITS-1]) begin
			sel_z = (lo_z <= hi_z) ? hi_z : lo_z;
		end else begin
			sel_z = (lo_z <= hi_z) ? lo_z : hi_z;
		end
	end

	assign prod_x = PROD_W'(a_c) * PROD_W'(sel_x);
	assign prod_y = PROD_W'(b_c) * PROD_W'(sel_y);
	assign prod_z = PROD_W'(c_c) * PROD_W'(sel_z);

	// first stage: products of the nearest corner
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_x_s1 <= prod_x;
			prod_y_s1 <= prod_y;
			prod_z_s1 <= prod_z;
			box_s1    <= box_in;
		end
	end

	// exact plane value at the nearest corner, outside when strictly positive
	assign sum = SUM_W'(prod_x_s1) + SUM_W'(prod_y_s1) + SUM_W'(prod_z_s1)
		+ (SUM_W'(d_c) <<< fbc_pkg::FRAC_BITS);
	assign outside = !sum[SUM_W-1] && (sum != '0);

	// second stage: fold verdict into the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (adv) begin
			ctl_s2.valid  <= ctl_s1.valid;
			ctl_s2.culled <= ctl_s1.culled | outside;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			box_s2 <= box_s1;
		end
	end

	assign ctl_out = ctl_s2;
	assign box_out = box_s2;

`ifndef SYNTH
	// a culled request stays culled through the cell
	a_keep_culled_s1: assert property (@(posedge clk) disable iff (!arst_n)
		adv && ctl_in.valid && ctl_in.culled |=> ctl_s1.culled)
		else $error("culled flag lost entering cell");

	a_keep_culled_s2: assert property (@(posedge clk) disable iff (!arst_n)
		adv && ctl_s1.valid && ctl_s1.culled |=> ctl_s2.culled)
		else $error("culled flag lost leaving cell");

	// a frozen chain holds the cell output
	a_hold_when_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(ctl_s2))
		else $error("cell output moved while chain frozen");

	// an all-zero plane never culls
	a_zero_plane: assert property (@(posedge clk) disable iff (!arst_n)
		adv && ctl_s1.valid && !ctl_s1.culled && (plane_q == '0) |=> !ctl_s2.culled)
		else $error("zero plane culled a request");
`endif

endmodule

/* design/frustum_box_cull_top.sv */
// top level of the frustum box cull block: a chain of plane test cells
// Each request is one axis-aligned box; it walks through one cell per plane, two
// pipeline stages in each (nearest-corner products, then exact sum and sign test),
// and a new box is taken every cycle while in_stall is low. The whole chain moves
// together: it advances whenever the result register is empty or its result is
// being taken, so in_stall follows out_stall while a result waits. is_culled is 1
// when all eight corners lie strictly outside at least one plane; a corner on a
// plane counts as inside. Plane i is written through cfg_index i; the user must do
// so only while no box is in flight; the block does not enforce it. Indexes at or
// beyond PLANE_COUNT ignore writes, and all planes reset to zero, which never culls.
module frustum_box_cull_top #(
	parameter int PLANE_COUNT = 6,
	parameter int COORD_BITS  = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [fbc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [fbc_pkg::PLANE_BITS-1:0]       cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [COORD_BITS-1:0]         box_min_x,
	input  logic signed [COORD_BITS-1:0]         box_min_y,
	input  logic signed [COORD_BITS-1:0]         box_min_z,
	input  logic signed [COORD_BITS-1:0]         box_max_x,
	input  logic signed [COORD_BITS-1:0]         box_max_y,
	input  logic signed [COORD_BITS-1:0]         box_max_z,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 is_culled
);

	fbc_pkg::chain_ctl_t     ctl  [PLANE_COUNT+1];
	logic [6*COORD_BITS-1:0] box  [PLANE_COUNT+1];
	logic                    adv;

	// chain moves when the last stage is free or being drained
	assign adv      = !ctl[PLANE_COUNT].valid || !out_stall;
	assign in_stall = !adv;

	// head of the chain
	assign ctl[0].valid  = in_valid;
	assign ctl[0].culled = 1'b0;
	assign box[0] = {box_max_z, box_max_y, box_max_x, box_min_z, box_min_y, box_min_x};

	// one cell per plane
	for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_cell
		fbc_cell #(
			.COORD_BITS (COORD_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.adv        (adv),
			.plane_we   (cfg_we && (cfg_index == fbc_pkg::CFG_INDEX_BITS'(p))),
			.plane_data (cfg_data),
			.ctl_in     (ctl[p]),
			.box_in     (box[p]),
			.ctl_out    (ctl[p+1]),
			.box_out    (box[p+1])
		);
	end

	// result from the tail of the chain
	assign out_valid = ctl[PLANE_COUNT].valid;
	assign is_culled = ctl[PLANE_COUNT].culled;

endmodule
